### src/psrq_pkg.sv
package psrq_pkg;

  // default store depth
  localparam int unsigned MaxPointsDef = 63;

  // coordinate and radius width
  localparam int unsigned CoordW = 16;

  // one stored point: x, y, z
  localparam int unsigned PointW = 3 * CoordW;

  // difference operand width, wide enough for any coordinate difference or the radius
  localparam int unsigned DiffW = CoordW + 1;

  // squared difference and its three-term sum
  localparam int unsigned AccW = 2 * DiffW;

  // radius squared width
  localparam int unsigned RadSqW = 2 * CoordW;

  // command to the shared square-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } sq_cmd_t;

endpackage

### src/psrq_sq_unit.sv
// shared square-and-accumulate unit: acc = sum over a command run of (a - b)^2
module psrq_sq_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  psrq_pkg::sq_cmd_t                  cmd_i,
  input  logic signed [psrq_pkg::DiffW-1:0]  a_i,
  input  logic signed [psrq_pkg::DiffW-1:0]  b_i,
  output logic                               done_o,
  output logic        [psrq_pkg::AccW-1:0]   acc_o
);

  psrq_pkg::sq_cmd_t                  cmd1_q, cmd2_q;
  logic signed [psrq_pkg::DiffW-1:0]  diff_q;
  logic signed [psrq_pkg::AccW-1:0]   sq;
  logic        [psrq_pkg::AccW-1:0]   prod_q;
  logic        [psrq_pkg::AccW-1:0]   acc_q;
  logic                               done_q;

  assign sq = diff_q * diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd1_q <= '0;
      cmd2_q <= '0;
      done_q <= 1'b0;
    end else begin
      cmd1_q <= cmd_i;
      cmd2_q <= cmd1_q;
      done_q <= cmd2_q.valid & cmd2_q.last;
    end
  end

  // subtract, square, accumulate: one register after each
  always_ff @(posedge clk_i) begin
    diff_q <= a_i - b_i;
    prod_q <= sq;
    if (cmd2_q.valid) begin
      acc_q <= (cmd2_q.first ? '0 : acc_q) + prod_q;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

### src/point_store_radius_query.sv
// Point store with fixed-radius query. An add transaction (kind 0) stores a
// point and widens the x/y bounding box; when the store is full the point is
// dropped and the sticky overflow flag is set. A query transaction (kind 1)
// scans the stored points in insertion order and returns one transaction per
// point whose squared distance is strictly below radius squared, then one
// summary transaction (last = 1) with the nearest such point, the small-region
// flag and the overflow flag. All squaring runs through one shared
// subtract-square-accumulate unit with a three-stage pipeline. A query first
// squares the radius, then for each stored point does one memory read, three
// axis issues and a wait for the pipeline to drain, with one more step for
// each match, and ends with the summary; output stalls hold the scan. The
// input is not ready while a query runs.
module point_store_radius_query #(
  parameter int unsigned MaxPoints = psrq_pkg::MaxPointsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic signed [psrq_pkg::CoordW-1:0]  px_i,
  input  logic signed [psrq_pkg::CoordW-1:0]  py_i,
  input  logic signed [psrq_pkg::CoordW-1:0]  pz_i,
  input  logic        [psrq_pkg::CoordW-1:0]  radius_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                result_kind_o,
  output logic signed [psrq_pkg::CoordW-1:0]  out_x_o,
  output logic signed [psrq_pkg::CoordW-1:0]  out_y_o,
  output logic signed [psrq_pkg::CoordW-1:0]  out_z_o,
  output logic                                small_region_o,
  output logic                                overflowed_o,
  output logic                                last_o
);

  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned IW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned W  = psrq_pkg::CoordW;
  localparam int unsigned DW = psrq_pkg::DiffW;
  localparam int unsigned AW = psrq_pkg::AccW;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RAD   = 4'd1;  // issue radius squared
  localparam logic [3:0] S_RWAIT = 4'd2;  // wait for radius squared
  localparam logic [3:0] S_RD    = 4'd3;  // read stored point
  localparam logic [3:0] S_X     = 4'd4;
  localparam logic [3:0] S_Y     = 4'd5;
  localparam logic [3:0] S_Z     = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;  // wait for squared distance
  localparam logic [3:0] S_EMIT  = 4'd8;  // hand out a matched point
  localparam logic [3:0] S_SUM   = 4'd9;  // hand out the summary

  logic [3:0] state_q, state_d;

  // store and bookkeeping
  logic [psrq_pkg::PointW-1:0] mem_q [MaxPoints];
  logic [psrq_pkg::PointW-1:0] rd_q;
  logic [CW-1:0]               count_q;
  logic [IW-1:0]               idx_q, idx_d;
  logic signed [W-1:0]         min_x_q, max_x_q, min_y_q, max_y_q;
  logic                        ovf_q;

  // query context
  logic signed [W-1:0]         qx_q, qy_q, qz_q;
  logic [W-1:0]                rad_q;
  logic                        small_q;
  logic [psrq_pkg::RadSqW-1:0] r2_q;
  logic [AW-1:0]               best_q;
  logic [psrq_pkg::PointW-1:0] near_q;

  // output register
  logic                        ov_q;
  logic                        okind_q, osmall_q, oovf_q;
  logic [psrq_pkg::PointW-1:0] opt_q;

  logic in_acc, is_add, is_query, store_full, out_free, out_load, last_pt;
  logic [W:0] width, height;
  logic [AW-1:0] r2_ext;

  psrq_pkg::sq_cmd_t     cmd;
  logic signed [DW-1:0]  op_a, op_b;
  logic                  sq_done;
  logic [AW-1:0]         sq_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign is_add     = in_acc & ~kind_i;
  assign is_query   = in_acc & kind_i;
  assign store_full = (count_q == CW'(MaxPoints));
  assign out_free   = ~ov_q | out_ready_i;
  assign last_pt    = ((CW'(idx_q) + CW'(1)) == count_q);
  assign r2_ext     = AW'(r2_q);

  // box extent, never negative since max >= min
  assign width  = (W+1)'($signed({max_x_q[W-1], max_x_q}) - $signed({min_x_q[W-1], min_x_q}));
  assign height = (W+1)'($signed({max_y_q[W-1], max_y_q}) - $signed({min_y_q[W-1], min_y_q}));

  // operand selection for the shared unit
  always_comb begin
    cmd  = '0;
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      S_RAD: begin
        cmd  = '{valid: 1'b1, first: 1'b1, last: 1'b1};
        op_a = $signed({1'b0, rad_q});
      end
      S_X: begin
        cmd  = '{valid: 1'b1, first: 1'b1, last: 1'b0};
        op_a = DW'(signed'(rd_q[3*W-1:2*W]));
        op_b = DW'(qx_q);
      end
      S_Y: begin
        cmd  = '{valid: 1'b1, first: 1'b0, last: 1'b0};
        op_a = DW'(signed'(rd_q[2*W-1:W]));
        op_b = DW'(qy_q);
      end
      S_Z: begin
        cmd  = '{valid: 1'b1, first: 1'b0, last: 1'b1};
        op_a = DW'(signed'(rd_q[W-1:0]));
        op_b = DW'(qz_q);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  psrq_sq_unit u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (sq_done),
    .acc_o  (sq_acc)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_query) state_d = S_RAD;
      end
      S_RAD: state_d = S_RWAIT;
      S_RWAIT: begin
        if (sq_done) begin
          idx_d   = '0;
          state_d = (count_q == '0) ? S_SUM : S_RD;
        end
      end
      S_RD: state_d = S_X;
      S_X:  state_d = S_Y;
      S_Y:  state_d = S_Z;
      S_Z:  state_d = S_WAIT;
      S_WAIT: begin
        if (sq_done) begin
          if (sq_acc < r2_ext) begin
            state_d = S_EMIT;
          end else if (last_pt) begin
            state_d = S_SUM;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_RD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (last_pt) begin
            state_d = S_SUM;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_RD;
          end
        end
      end
      S_SUM: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = out_free & ((state_q == S_EMIT) | (state_q == S_SUM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      min_x_q <= '0;
      max_x_q <= '0;
      min_y_q <= '0;
      max_y_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      // add transaction: store, widen box, or flag overflow
      if (is_add) begin
        if (store_full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
          if (count_q == '0) begin
            min_x_q <= px_i;
            max_x_q <= px_i;
            min_y_q <= py_i;
            max_y_q <= py_i;
          end else begin
            if (px_i < min_x_q) min_x_q <= px_i;
            if (px_i > max_x_q) max_x_q <= px_i;
            if (py_i < min_y_q) min_y_q <= py_i;
            if (py_i > max_y_q) max_y_q <= py_i;
          end
        end
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // point store, written on add and read one point at a time
  always_ff @(posedge clk_i) begin
    if (is_add && !store_full) begin
      mem_q[count_q[IW-1:0]] <= {px_i, py_i, pz_i};
    end
    if (state_q == S_RD) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // query context and nearest tracking
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      qx_q    <= px_i;
      qy_q    <= py_i;
      qz_q    <= pz_i;
      rad_q   <= radius_i;
      small_q <= ({1'b0, radius_i} > width) && ({1'b0, radius_i} > height);
    end
    if (state_q == S_RWAIT && sq_done) begin
      r2_q   <= sq_acc[psrq_pkg::RadSqW-1:0];
      best_q <= sq_acc;
      near_q <= '0;
    end
    if (state_q == S_WAIT && sq_done) begin
      // strict compare keeps the earlier point on a tie
      if (sq_acc < best_q) begin
        best_q <= sq_acc;
        near_q <= rd_q;
      end
    end
    if (out_load) begin
      okind_q  <= (state_q == S_SUM);
      opt_q    <= (state_q == S_SUM) ? near_q : rd_q;
      osmall_q <= (state_q == S_SUM) & small_q;
      oovf_q   <= (state_q == S_SUM) & ovf_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign result_kind_o  = okind_q;
  assign out_x_o        = opt_q[3*W-1:2*W];
  assign out_y_o        = opt_q[2*W-1:W];
  assign out_z_o        = opt_q[W-1:0];
  assign small_region_o = osmall_q;
  assign overflowed_o   = oovf_q;
  assign last_o         = okind_q;

endmodule

### src/psrq_checker.sv
module psrq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                kind_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                result_kind_o,
  input logic signed [psrq_pkg::CoordW-1:0]  out_x_o,
  input logic signed [psrq_pkg::CoordW-1:0]  out_y_o,
  input logic signed [psrq_pkg::CoordW-1:0]  out_z_o,
  input logic                                small_region_o,
  input logic                                overflowed_o,
  input logic                                last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o)
      && $stable(out_z_o) && $stable(result_kind_o))
    else $error("stalled result changed");

  // point results carry no summary flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> !small_region_o && !overflowed_o && !last_o)
    else $error("summary flag on point result");

  // only the summary closes a query run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == result_kind_o))
    else $error("last does not match summary");

  // a query keeps the input closed while it scans
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i |=> !in_ready_o)
    else $error("input open right after a query");

endmodule

bind point_store_radius_query psrq_checker u_psrq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .kind_i         (kind_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .out_x_o        (out_x_o),
  .out_y_o        (out_y_o),
  .out_z_o        (out_z_o),
  .small_region_o (small_region_o),
  .overflowed_o   (overflowed_o),
  .last_o         (last_o)
);

### sim/psrq_checker.sv
`timescale 1ns / 1ps

package psrq_tb_pkg;

  typedef enum logic {
    KindAdd   = 1'b0,
    KindQuery = 1'b1
  } item_kind_e;

  typedef enum logic {
    ResPoint   = 1'b0,
    ResSummary = 1'b1
  } result_kind_e;

endpackage

module psrq_tb_checker #(
  parameter int unsigned MaxPoints = psrq_pkg::MaxPointsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               kind_i,
  input  logic signed [psrq_pkg::CoordW-1:0] px_i,
  input  logic signed [psrq_pkg::CoordW-1:0] py_i,
  input  logic signed [psrq_pkg::CoordW-1:0] pz_i,
  input  logic        [psrq_pkg::CoordW-1:0] radius_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic                               result_kind_i,
  input  logic signed [psrq_pkg::CoordW-1:0] out_x_i,
  input  logic signed [psrq_pkg::CoordW-1:0] out_y_i,
  input  logic signed [psrq_pkg::CoordW-1:0] out_z_i,
  input  logic                               small_region_i,
  input  logic                               overflowed_i,
  input  logic                               last_i,
  output int unsigned                        mismatches_o,
  output int unsigned                        outstanding_o,
  output int unsigned                        in_radius_o
);

  localparam int unsigned CW   = psrq_pkg::CoordW;
  localparam int unsigned IdxW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    psrq_tb_pkg::result_kind_e kind;
    point_t                    pt;
    logic                      small_region;
    logic                      overflowed;
    logic                      last_flag;
  } query_result_t;

  point_t        stored_pts [MaxPoints];
  int unsigned   n_stored;
  coord_t        box_min_x, box_max_x, box_min_y, box_max_y;
  logic          overflow_seen;
  query_result_t hit_and_summary_q [$];
  int unsigned   n_mismatch;
  int unsigned   n_in_radius;

  function automatic logic [35:0] axis_sq(coord_t a, coord_t b);
    logic signed [35:0] diff;
    diff = 36'(a) - 36'(b);
    return diff * diff;
  endfunction

  function automatic void queue_result(query_result_t res);
    hit_and_summary_q.insert(hit_and_summary_q.size(), res);
  endfunction

  task automatic add_point(coord_t x, coord_t y, coord_t z);
    if (n_stored >= MaxPoints) begin
      overflow_seen = 1'b1;
    end else begin
      if (n_stored == 0) begin
        box_min_x = x;
        box_max_x = x;
        box_min_y = y;
        box_max_y = y;
      end else begin
        if (x < box_min_x) box_min_x = x;
        if (x > box_max_x) box_max_x = x;
        if (y < box_min_y) box_min_y = y;
        if (y > box_max_y) box_max_y = y;
      end
      stored_pts[IdxW'(n_stored)] = '{x: x, y: y, z: z};
      n_stored++;
    end
  endtask

  // in-radius points in store order, then the summary
  task automatic scan_store(coord_t qx, coord_t qy, coord_t qz, logic [CW-1:0] rad);
    logic [35:0]   r2;
    logic [35:0]   d2;
    logic [35:0]   best;
    logic [CW:0]   width;
    logic [CW:0]   height;
    point_t        nearest;
    query_result_t res;
    r2      = 36'(rad) * 36'(rad);
    best    = r2;
    width   = (CW+1)'(box_max_x) - (CW+1)'(box_min_x);
    height  = (CW+1)'(box_max_y) - (CW+1)'(box_min_y);
    nearest = '0;
    for (int unsigned i = 0; i < n_stored; i++) begin
      d2 = axis_sq(stored_pts[IdxW'(i)].x, qx) + axis_sq(stored_pts[IdxW'(i)].y, qy)
         + axis_sq(stored_pts[IdxW'(i)].z, qz);
      if (d2 < r2) begin
        res      = '0;
        res.kind = psrq_tb_pkg::ResPoint;
        res.pt   = stored_pts[IdxW'(i)];
        queue_result(res);
      end
      // strict compare keeps the earlier point on a tie
      if (d2 < best) begin
        best    = d2;
        nearest = stored_pts[IdxW'(i)];
      end
    end
    res              = '0;
    res.kind         = psrq_tb_pkg::ResSummary;
    res.pt           = nearest;
    res.small_region = (rad > width) && (rad > height);
    res.overflowed   = overflow_seen;
    res.last_flag    = 1'b1;
    queue_result(res);
  endtask

  task automatic check_field(string field, logic [CW-1:0] want_v, logic [CW-1:0] got_v);
    if (got_v !== want_v) begin
      n_mismatch++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    query_result_t got;
    query_result_t want;
    if (!rst_ni) begin
      hit_and_summary_q.delete();
      n_stored      = 0;
      box_min_x     = '0;
      box_max_x     = '0;
      box_min_y     = '0;
      box_max_y     = '0;
      overflow_seen = 1'b0;
      n_mismatch    = 0;
      n_in_radius   = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
      in_radius_o   <= 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        got.kind         = psrq_tb_pkg::result_kind_e'(result_kind_i);
        got.pt.x         = out_x_i;
        got.pt.y         = out_y_i;
        got.pt.z         = out_z_i;
        got.small_region = small_region_i;
        got.overflowed   = overflowed_i;
        got.last_flag    = last_i;
        if (got.kind == psrq_tb_pkg::ResPoint) n_in_radius++;
        if (hit_and_summary_q.size() == 0) begin
          n_mismatch++;
          $display("%0t: unexpected result, expected none, actual kind %0d at %h %h %h",
                   $time, got.kind, got.pt.x, got.pt.y, got.pt.z);
        end else begin
          want = hit_and_summary_q.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("out_x", want.pt.x, got.pt.x);
          check_field("out_y", want.pt.y, got.pt.y);
          check_field("out_z", want.pt.z, got.pt.z);
          check_field("small_region", want.small_region, got.small_region);
          check_field("overflowed", want.overflowed, got.overflowed);
          check_field("last", want.last_flag, got.last_flag);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (psrq_tb_pkg::item_kind_e'(kind_i) == psrq_tb_pkg::KindAdd) begin
          add_point(px_i, py_i, pz_i);
        end else begin
          scan_store(px_i, py_i, pz_i, radius_i);
        end
      end
      mismatches_o  <= n_mismatch;
      outstanding_o <= hit_and_summary_q.size();
      in_radius_o   <= n_in_radius;
    end
  end

endmodule

### sim/tb_point_store_radius_query.sv
`timescale 1ns / 1ps

module tb_point_store_radius_query;

  localparam int unsigned CW          = psrq_pkg::CoordW;
  localparam int unsigned StoreDepth  = psrq_pkg::MaxPointsDef;
  // a full scan with no hits passes with no transaction on either channel
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned FullQueries = 76;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    RecvFree,
    RecvLight,
    RecvHeavy
  } recv_mode_e;

  logic             clk;
  logic             rst_n;

  logic             in_valid;
  logic             in_ready;
  logic             kind;
  coord_t           px, py, pz;
  logic [CW-1:0]    radius;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             result_kind;
  coord_t           out_x, out_y, out_z;
  logic             small_region;
  logic             overflowed;
  logic             last_flag;

  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      in_radius;

  // stimulus bookkeeping
  int unsigned      n_adds     = 0;
  int unsigned      n_dropped  = 0;
  int unsigned      n_queries  = 0;
  int unsigned      n_held     = 0;
  int unsigned      burst_left = 0;

  recv_mode_e       recv_mode  = RecvFree;
  int unsigned      mode_left  = 0;
  int unsigned      idle_cycles = 0;

  point_store_radius_query i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .px_i           (px),
    .py_i           (py),
    .pz_i           (pz),
    .radius_i       (radius),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_z_o        (out_z),
    .small_region_o (small_region),
    .overflowed_o   (overflowed),
    .last_o         (last_flag)
  );

  psrq_tb_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .kind_i         (kind),
    .px_i           (px),
    .py_i           (py),
    .pz_i           (pz),
    .radius_i       (radius),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_i  (result_kind),
    .out_x_i        (out_x),
    .out_y_i        (out_y),
    .out_z_i        (out_z),
    .small_region_i (small_region),
    .overflowed_i   (overflowed),
    .last_i         (last_flag),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .in_radius_o    (in_radius)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: modes of free flow, light stalls and heavy stalls, each held
  // for a random stretch so stalls land on every phase of a scan
  always @(posedge clk) begin
    if (mode_left == 0) begin
      recv_mode <= recv_mode_e'($urandom_range(0, 2));
      mode_left <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (recv_mode)
      RecvFree:  out_ready <= 1'b1;
      RecvLight: out_ready <= ($urandom_range(0, 3) != 0);
      default:   out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly a cluster around the origin so queries find neighbors,
  // sometimes anywhere in the full range
  function automatic coord_t pick_coord();
    if ($urandom_range(0, 7) == 0) return coord_t'($urandom_range(0, 65535));
    return coord_t'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  function automatic logic [CW-1:0] pick_radius();
    case ($urandom_range(0, 9))
      0:       return CW'($urandom_range(0, 65535));
      1:       return CW'($urandom_range(0, 64));
      default: return CW'($urandom_range(64, 2200));
    endcase
  endfunction

  // called at a rising edge; returns at the edge that takes the transaction,
  // or after the gap that follows a burst
  task automatic send_item(psrq_tb_pkg::item_kind_e k, coord_t x, coord_t y, coord_t z,
                           logic [CW-1:0] r);
    in_valid <= 1'b1;
    kind     <= k;
    px       <= x;
    py       <= y;
    pz       <= z;
    radius   <= r;
    do @(posedge clk); while (!in_ready);
    if (k == psrq_tb_pkg::KindAdd) begin
      n_adds++;
      if (n_held < StoreDepth) n_held++;
      else n_dropped++;
    end else begin
      n_queries++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_random_add();
    send_item(psrq_tb_pkg::KindAdd, pick_coord(), pick_coord(), pick_coord(),
              CW'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_query();
    send_item(psrq_tb_pkg::KindQuery, pick_coord(), pick_coord(), pick_coord(),
              pick_radius());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    kind      = psrq_tb_pkg::KindAdd;
    px        = '0;
    py        = '0;
    pz        = '0;
    radius    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store: summary only; small region exactly when radius is nonzero
    send_item(psrq_tb_pkg::KindQuery, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_item(psrq_tb_pkg::KindQuery, -16'sd32768, -16'sd32768, -16'sd32768, 16'hFFFF);
    // two points at equal distance from the origin
    send_item(psrq_tb_pkg::KindAdd, 16'sd256, 16'sd0, 16'sd0, 16'd0);
    send_item(psrq_tb_pkg::KindAdd, -16'sd256, 16'sd0, 16'sd0, 16'hFFFF);
    // zero radius never matches
    send_item(psrq_tb_pkg::KindQuery, 16'sd0, 16'sd0, 16'sd0, 16'd0);
    // distance equal to radius is outside
    send_item(psrq_tb_pkg::KindQuery, 16'sd0, 16'sd0, 16'sd0, 16'd256);
    // both inside, tie goes to the earlier point
    send_item(psrq_tb_pkg::KindQuery, 16'sd0, 16'sd0, 16'sd0, 16'd257);
    send_item(psrq_tb_pkg::KindAdd, 16'sd0, 16'sd128, 16'sd0, 16'd0);
    // radius wider than the box in both axes
    send_item(psrq_tb_pkg::KindQuery, 16'sd0, 16'sd0, 16'sd0, 16'd600);
    send_item(psrq_tb_pkg::KindQuery, 16'sd0, 16'sd0, -16'sd32768, 16'hFFFF);

    // fill the store with queries mixed in, leaving two slots
    while (n_held < StoreDepth - 2) begin
      if ($urandom_range(0, 2) == 0) send_random_query();
      else send_random_add();
    end

    // extreme corners take the last two slots, then the store is full
    send_item(psrq_tb_pkg::KindAdd, -16'sd32768, 16'sd32767, -16'sd32768, 16'd0);
    send_item(psrq_tb_pkg::KindAdd, 16'sd32767, -16'sd32768, 16'sd32767, 16'd0);
    send_item(psrq_tb_pkg::KindAdd, 16'sd1, 16'sd2, 16'sd3, 16'd5);
    send_item(psrq_tb_pkg::KindQuery, -16'sd32768, 16'sd32767, -16'sd32768, 16'hFFFF);
    send_item(psrq_tb_pkg::KindQuery, 16'sd32767, -16'sd32768, 16'sd32767, 16'd1);
    send_item(psrq_tb_pkg::KindQuery, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF);
    send_item(psrq_tb_pkg::KindAdd, 16'sd32767, 16'sd32767, 16'sd32767, 16'd0);

    // full store: mostly queries, the odd dropped add
    repeat (FullQueries) begin
      if ($urandom_range(0, 7) == 0) send_random_add();
      else send_random_query();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d adds (%0d dropped on a full store) and %0d queries",
             n_adds, n_dropped, n_queries);
    $display("checked %0d in-radius points and %0d query summaries", in_radius, n_queries);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### point_store_radius_query.f
src/psrq_pkg.sv
src/psrq_sq_unit.sv
src/point_store_radius_query.sv
src/psrq_checker.sv
sim/psrq_checker.sv
sim/tb_point_store_radius_query.sv
